// ===== rtl/bmp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_pkg: shared types and constants of the BMP stream decoder
// Result kinds, error codes, parser phases and the front-to-back job record.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;
	localparam logic [5:0]  HEADER_END    = 6'd53;
	localparam logic [31:0] PALETTE_START = 32'd54;
	localparam logic [31:0] INFO_SIZE     = 32'd40;

	typedef enum logic [2:0] {
		KIND_PALETTE = 3'd0,
		KIND_INDEX   = 3'd1,
		KIND_COLOR   = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NOT_BMP    = 3'd0,
		ERR_OLD_HEADER = 3'd1,
		ERR_COMPRESSED = 3'd2,
		ERR_DEPTH      = 3'd3,
		ERR_TOO_LARGE  = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_PALETTE,
		PH_SKIP,
		PH_PIXELS,
		PH_HALT
	} phase_t;

	// one job covers all results of one input byte: a single result, or a
	// packed byte of 1..8 index pixels starting at col
	typedef struct packed {
		kind_t       kind;
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0]  index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		err_t        error_code;
		logic        unpack;    // index pixels from index byte
		logic [1:0]  dsel;      // 0:1 bit, 1:4 bit, 2:8 bit
		logic [3:0]  count;     // pixels of an unpack job, 1..8
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/bmp_stream_decoder_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_stream_decoder_unit: uncompressed BMP byte stream decoder
// Parses headers and palette, unpacks bottom-up pixel rows into results.
// ----------------------------------------------------------------------------
// channel  dir  tdata                         tuser       tlast
// s_axis   in   data_byte[7:0]                start_req   -
// m_axis   out  col,row,index,red,green,blue  kind,error  last
//
// One byte is parsed per cycle and makes at most one job in a 4-entry queue.
// The expander emits one result per cycle while the sink is ready: a 1-bit byte
// gives up to 8 results; a job that ends the image (last row closed without
// padding, or last palette entry of an empty image) adds an image-done result.
// Reset leaves the parser waiting for a start byte; the input stalls only
// when the queue is full.
module bmp_stream_decoder_unit #(
	parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // data_byte
	input  wire logic        s_axis_tuser,  // start_req
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [63:0]      m_axis_tdata,  // col,row,index,red,green,blue
	output logic [5:0]       m_axis_tuser,  // kind[2:0],error_code[5:3]
	output logic             m_axis_tlast
);
	import bmp_pkg::*;

	localparam int JW = $bits(job_t) + 1;

	logic          fv, fd, full, empty, pop, qdone, bready;
	job_t          fj, qj, r;
	logic [JW-1:0] qd;
	logic          acc;

	assign s_axis_tready = !full;
	assign acc = s_axis_tvalid && !full;

	bmp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .in_valid(acc), .in_byte(s_axis_tdata),
		.in_start(s_axis_tuser), .job_valid(fv), .job(fj), .job_done(fd)
	);

	bmp_queue #(.W(JW)) u_queue (
		.clk, .arst_n, .push(acc && fv), .wdata({fd, fj}), .full,
		.pop, .empty, .rdata(qd)
	);
	assign qj = qd[JW-2:0];
	assign qdone = qd[JW-1];

	bmp_back u_back (
		.clk, .arst_n, .job_valid(!empty), .job(qj), .job_done(qdone),
		.job_ready(bready), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res(r), .res_last(m_axis_tlast)
	);
	assign pop = bready && !empty;

	assign m_axis_tdata = {r.blue, r.green, r.red, r.index, r.row, r.col};
	assign m_axis_tuser = {r.error_code, r.kind};
endmodule
`default_nettype wire

// ===== rtl/bmp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_front: header parser and byte classifier
// Takes one file byte a cycle, while the queue is not full, and turns it into at most one job.
// ----------------------------------------------------------------------------
module bmp_front #(
	parameter int COORD_BITS = bmp_pkg::COORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	input  wire logic [7:0]   in_byte,
	input  wire logic         in_start,
	output logic              job_valid,
	output bmp_pkg::job_t     job,
	output logic              job_done   // image done follows this job
);
	import bmp_pkg::*;

	localparam logic [32:0] LIMIT = (33'd1 << COORD_BITS) - 33'd1;

	phase_t      phase_q, phase_n;
	logic [5:0]  hpos_q;
	logic [31:0] fpos_q, shift_q, offset_q, width_q, height_q;
	logic [4:0]  depth_q;
	logic [8:0]  ptotal_q, pslot_q;
	logic [23:0] gather_q;
	logic [1:0]  bphase_q;
	logic [32:0] col_q;
	logic [31:0] row_q;
	logic [1:0]  rmod_q, pad_q;

	logic [31:0] shift_n, fpos_n, cnt;
	logic [15:0] half;
	logic [8:0]  ptot_n;
	logic [23:0] g_n;
	logic [32:0] col_n;
	logic [1:0]  rmod_n, pad_n;
	logic [3:0]  per;
	logic        ph_ok;
	job_t        j;
	logic        jv;
	logic        jd;

	// state after a start byte is seen
	phase_t      ph_e;
	logic [5:0]  hpos_e;
	logic [31:0] fpos_e, shift_e;

	always_comb begin
		ph_e = in_start ? PH_HEADER : phase_q;
		hpos_e = in_start ? 6'd0 : hpos_q;
		fpos_e = in_start ? 32'd0 : fpos_q;
		shift_e = in_start ? 32'd0 : shift_q;
		fpos_n = fpos_e + 32'd1;
		shift_n = {in_byte, shift_e[31:8]};
		half = shift_n[31:16];
		cnt = (offset_q - PALETTE_START) >> 2;
		ptot_n = (depth_q != 5'd24 && offset_q >= PALETTE_START)
			? ((cnt > 32'd256) ? 9'd256 : cnt[8:0]) : 9'd0;
		g_n = gather_q | ({16'd0, in_byte} << {bphase_q, 3'd0});
		unique case (depth_q)
			5'd1:    per = 4'd8;
			5'd4:    per = 4'd2;
			default: per = 4'd1;
		endcase
		col_n = col_q + 33'(per);
		rmod_n = rmod_q + 2'd1;
		pad_n = 2'd0 - rmod_n;
	end

	always_comb begin
		j = '0;
		jv = 1'b0;
		jd = 1'b0;
		phase_n = ph_e;
		ph_ok = (ph_e != PH_IDLE) && (ph_e != PH_HALT);
		if (in_valid && ph_ok) begin
			unique case (ph_e)
				PH_HEADER: begin
					if (hpos_e == 6'd1 && (half[7:0] != 8'h42 || in_byte != 8'h4D)) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_NOT_BMP;
					end else if (hpos_e == 6'd17 && shift_n != INFO_SIZE) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_OLD_HEADER;
					end else if (hpos_e == 6'd27 && half != 16'd1) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_COMPRESSED;
					end else if (hpos_e == 6'd33 && shift_n != 32'd0) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_COMPRESSED;
					end else if (hpos_e == 6'd33 && depth_q == 5'd0) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_DEPTH;
					end else if (hpos_e == 6'd33 && ({1'b0, width_q} > LIMIT
						|| {1'b0, height_q} > LIMIT)) begin
						jv = 1'b1; j.kind = KIND_ERROR; j.error_code = ERR_TOO_LARGE;
					end else if (hpos_e >= HEADER_END) begin
						if (ptot_n != 9'd0) phase_n = PH_PALETTE;
						else if (fpos_n < offset_q) phase_n = PH_SKIP;
						else if (width_q == 32'd0 || height_q == 32'd0) begin
							jv = 1'b1; j.kind = KIND_DONE;
						end else phase_n = PH_PIXELS;
					end
					if (jv) phase_n = PH_HALT;
				end
				PH_PALETTE: begin
					if (bphase_q == 2'd3) begin
						jv = 1'b1; j.kind = KIND_PALETTE; j.index = pslot_q[7:0];
						j.red = gather_q[23:16]; j.green = gather_q[15:8];
						j.blue = gather_q[7:0];
						if (pslot_q + 9'd1 >= ptotal_q) begin
							if (fpos_n < offset_q) phase_n = PH_SKIP;
							else if (width_q == 32'd0 || height_q == 32'd0) begin
								// empty image: done follows the last palette entry
								jd = 1'b1; phase_n = PH_HALT;
							end else phase_n = PH_PIXELS;
						end
					end
				end
				PH_SKIP: begin
					if (fpos_n >= offset_q) begin
						if (width_q == 32'd0 || height_q == 32'd0) begin
							jv = 1'b1; j.kind = KIND_DONE; phase_n = PH_HALT;
						end else phase_n = PH_PIXELS;
					end
				end
				PH_PIXELS: begin
					if (pad_q != 2'd0) begin
						if (pad_q == 2'd1 && row_q == 32'd0) begin
							jv = 1'b1; j.kind = KIND_DONE; phase_n = PH_HALT;
						end
					end else begin
						j.row = row_q[15:0]; j.col = col_q[15:0];
						if (depth_q == 5'd24) begin
							if (bphase_q == 2'd2) begin
								jv = 1'b1; j.kind = KIND_COLOR;
								j.red = g_n[23:16]; j.green = g_n[15:8]; j.blue = g_n[7:0];
							end
						end else begin
							j.kind = KIND_INDEX; j.unpack = 1'b1; j.index = in_byte;
							j.dsel = (depth_q == 5'd1) ? 2'd0 : (depth_q == 5'd4) ? 2'd1 : 2'd2;
							j.count = ({1'b0, width_q} - col_q >= 33'(per)) ? per
								: 4'(width_q[3:0] - col_q[3:0]);
							jv = 1'b1;
						end
						// last row (row 0) closed without padding: done follows the pixels
						if (jv && col_n >= {1'b0, width_q} && pad_n == 2'd0
							&& row_q == 32'd0) begin
							jd = 1'b1; phase_n = PH_HALT;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign job_valid = jv;
	assign job = j;
	assign job_done = jd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; hpos_q <= '0; fpos_q <= '0; shift_q <= '0;
			offset_q <= '0; width_q <= '0; height_q <= '0; depth_q <= '0;
			ptotal_q <= '0; pslot_q <= '0; gather_q <= '0; bphase_q <= '0;
			col_q <= '0; row_q <= '0; rmod_q <= '0; pad_q <= '0;
		end else if (in_valid) begin
			phase_q <= phase_n;
			// position, byte count and word gather restart through the _e values
			if (in_start) begin
				offset_q <= '0;
				width_q <= '0; height_q <= '0; depth_q <= '0; ptotal_q <= '0;
				pslot_q <= '0; gather_q <= '0; bphase_q <= '0; col_q <= '0;
				row_q <= '0; rmod_q <= '0; pad_q <= '0;
			end
			if (ph_ok) begin
				fpos_q <= fpos_n;
				if (phase_n == PH_PIXELS && ph_e != PH_PIXELS) begin
					row_q <= height_q - 32'd1;
					col_q <= '0; rmod_q <= '0; pad_q <= '0;
					bphase_q <= '0; gather_q <= '0;
				end
				unique case (ph_e)
					PH_HEADER: begin
						shift_q <= shift_n;
						if (hpos_e == 6'd13) offset_q <= shift_n;
						if (hpos_e == 6'd21) width_q <= shift_n;
						if (hpos_e == 6'd25) height_q <= shift_n;
						if (hpos_e == 6'd29)
							depth_q <= (half == 16'd1 || half == 16'd4 || half == 16'd8
								|| half == 16'd24) ? half[4:0] : 5'd0;
						if (hpos_e >= HEADER_END) begin
							ptotal_q <= ptot_n; pslot_q <= '0;
							if (phase_n != PH_PIXELS) begin
								bphase_q <= '0; gather_q <= '0;
							end
						end else hpos_q <= hpos_e + 6'd1;
					end
					PH_PALETTE: begin
						if (bphase_q != 2'd3) begin
							gather_q <= g_n; bphase_q <= bphase_q + 2'd1;
						end else begin
							pslot_q <= pslot_q + 9'd1;
							if (phase_n != PH_PIXELS) begin
								gather_q <= '0; bphase_q <= '0;
							end
						end
					end
					PH_PIXELS: begin
						if (pad_q != 2'd0) begin
							pad_q <= pad_q - 2'd1;
							if (pad_q == 2'd1) begin
								row_q <= row_q - 32'd1; col_q <= '0; rmod_q <= '0;
							end
						end else if (depth_q == 5'd24 && bphase_q != 2'd2) begin
							rmod_q <= rmod_n; gather_q <= g_n; bphase_q <= bphase_q + 2'd1;
						end else begin
							if (depth_q == 5'd24) begin
								gather_q <= '0; bphase_q <= '0;
							end
							if (col_n < {1'b0, width_q}) begin
								rmod_q <= rmod_n; col_q <= col_n;
							end else if (pad_n != 2'd0) begin
								rmod_q <= rmod_n; pad_q <= pad_n;
							end else begin
								row_q <= row_q - 32'd1; col_q <= '0; rmod_q <= '0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bmp_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_back: result expander
// Pops jobs and emits their results, fanning a packed byte out into pixels.
// ----------------------------------------------------------------------------
module bmp_back (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       job_valid,
	input  wire bmp_pkg::job_t job,
	input  wire logic       job_done,   // image done follows this job
	output logic            job_ready,
	output logic            res_valid,
	input  wire logic       res_ready,
	output bmp_pkg::job_t   res,
	output logic            res_last
);
	import bmp_pkg::*;

	logic [3:0] k_q;
	logic       dpend_q;
	logic [3:0] bits;
	logic [7:0] sh;
	logic       fin;

	always_comb begin
		res = job;
		unique case (job.dsel)
			2'd0:    bits = 4'd1;
			2'd1:    bits = 4'd4;
			default: bits = 4'd8;
		endcase
		sh = job.index << (k_q * bits);
		res.unpack = 1'b0;
		if (dpend_q) begin
			res = '0; res.kind = KIND_DONE;
		end else if (job.unpack) begin
			res.col = job.col + 16'(k_q);
			unique case (job.dsel)
				2'd0:    res.index = {7'd0, sh[7]};
				2'd1:    res.index = {4'd0, sh[7:4]};
				default: res.index = sh;
			endcase
		end
		fin = dpend_q || !job.unpack || (k_q + 4'd1 >= job.count);
		res_last = fin && (dpend_q || !job_done);
		res_valid = job_valid;
		job_ready = res_ready && fin && (dpend_q || !job_done);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0; dpend_q <= 1'b0;
		end else if (job_valid && res_ready) begin
			if (dpend_q) begin
				dpend_q <= 1'b0; k_q <= '0;
			end else if (!fin) k_q <= k_q + 4'd1;
			else begin
				k_q <= '0;
				dpend_q <= job_done;
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/bmp_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmp_queue: job queue between parser and expander
// Small register FIFO; full flag stalls the byte input.
// ----------------------------------------------------------------------------
module bmp_queue #(
	parameter int W = 8,
	parameter int DEPTH = bmp_pkg::QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output logic [W-1:0]      rdata
);
	localparam int AW = $clog2(DEPTH);
	logic [W-1:0] mem_q [DEPTH];
	logic [AW:0]  wp_q, rp_q;

	assign empty = (wp_q == rp_q);
	assign full = (wp_q[AW-1:0] == rp_q[AW-1:0]) && (wp_q[AW] != rp_q[AW]);
	assign rdata = mem_q[rp_q[AW-1:0]];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q[AW-1:0]] <= wdata;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
		end
	end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bmp_stream_decoder_unit
// Feeds BMP byte streams (valid files of every depth, broken headers and
// noise) with random gaps on both sides, predicts each result item from a
// behavioral parser model and compares field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;
	import bmp_pkg::*;

	localparam int LIMIT_CYCLES = 20000;

	typedef struct {
		kind_t       kind;
		logic [15:0] col;
		logic [15:0] row;
		logic [7:0]  index;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		err_t        error_code;
		logic        last;
	} pix_t;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} byte_t;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
	logic [7:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
	logic [63:0] m_axis_tdata;
	logic [5:0] m_axis_tuser;

	bmp_stream_decoder_unit uut (.*);

	byte_t pending[$];
	pix_t  expected_pix[$];
	int    errors = 0;
	int    bytes_sent = 0, results_seen = 0, files_sent = 0;
	int    idle_cycles = 0;
	bit    stim_done = 0;
	bit    hold_sink = 0;

	// decoder model state
	phase_t m_phase;
	int unsigned m_hpos, m_fpos, m_shift, m_offset, m_width, m_height;
	int unsigned m_depth, m_pal_total, m_pal_slot, m_gather, m_bphase;
	longint unsigned m_col;
	int unsigned m_row, m_mod, m_pad;

	always begin
		clk = 1; #4;
		clk = 0; #4;
	end

	task automatic emit(kind_t k, longint unsigned c, int unsigned r, int unsigned ix,
			int unsigned rd, int unsigned g, int unsigned b, err_t e);
		pix_t p;
		p.kind = k; p.col = c[15:0]; p.row = r[15:0]; p.index = ix[7:0];
		p.red = rd[7:0]; p.green = g[7:0]; p.blue = b[7:0]; p.error_code = e;
		p.last = 0;
		expected_pix.push_back(p);
	endtask

	task automatic image_done();
		emit(KIND_DONE, 0, 0, 0, 0, 0, 0, ERR_NOT_BMP);
		m_phase = PH_HALT;
	endtask

	// only result of its byte
	task automatic bad_file(err_t e);
		emit(KIND_ERROR, 0, 0, 0, 0, 0, 0, e);
		expected_pix[expected_pix.size() - 1].last = 1;
		m_phase = PH_HALT;
	endtask

	task automatic begin_pixels();
		if (m_width == 0 || m_height == 0) begin
			image_done();
		end else begin
			m_phase = PH_PIXELS;
			m_row = m_height - 1; m_col = 0; m_mod = 0; m_pad = 0;
			m_bphase = 0; m_gather = 0;
		end
	endtask

	task automatic seek_pixels();
		if (m_fpos >= m_offset) begin
			begin_pixels();
		end else begin
			m_phase = PH_SKIP;
		end
	endtask

	task automatic close_row();
		if (m_row == 0) begin
			image_done();
		end else begin
			m_row--; m_col = 0; m_mod = 0; m_pad = 0;
		end
	endtask

	task automatic predict_byte(byte_t in);
		int unsigned b, half, per, mask, cnt;
		int n0;
		b = in.data;
		n0 = expected_pix.size();
		if (in.start) begin
			m_hpos = 0; m_fpos = 0; m_shift = 0; m_offset = 0; m_width = 0;
			m_height = 0; m_depth = 0; m_pal_total = 0; m_pal_slot = 0; m_gather = 0;
			m_bphase = 0; m_col = 0; m_row = 0; m_mod = 0; m_pad = 0;
			m_phase = PH_HEADER;
		end
		if (m_phase == PH_IDLE || m_phase == PH_HALT) return;
		m_fpos++;
		case (m_phase)
			PH_HEADER: begin
				m_shift = (m_shift >> 8) | (b << 24);
				half = m_shift >> 16;
				case (m_hpos)
					1: if ((half & 8'hFF) != "B" || b != "M") begin
						bad_file(ERR_NOT_BMP);
						return;
					end
					13: m_offset = m_shift;
					17: if (m_shift != INFO_SIZE) begin
						bad_file(ERR_OLD_HEADER);
						return;
					end
					21: m_width = m_shift;
					25: m_height = m_shift;
					27: if (half != 1) begin
						bad_file(ERR_COMPRESSED);
						return;
					end
					29: m_depth = (half == 1 || half == 4 || half == 8 || half == 24) ? half : 0;
					33: begin
						if (m_shift != 0) begin
							bad_file(ERR_COMPRESSED);
							return;
						end
						if (m_depth == 0) begin
							bad_file(ERR_DEPTH);
							return;
						end
						if (m_width > 16'hFFFF || m_height > 16'hFFFF) begin
							bad_file(ERR_TOO_LARGE);
							return;
						end
					end
					default: ;
				endcase
				if (m_hpos >= HEADER_END) begin
					m_pal_total = 0;
					if (m_depth != 24 && m_offset >= PALETTE_START) begin
						cnt = (m_offset - PALETTE_START) / 4;
						m_pal_total = cnt > 256 ? 256 : cnt;
					end
					m_pal_slot = 0; m_bphase = 0; m_gather = 0;
					if (m_pal_total > 0) m_phase = PH_PALETTE;
					else seek_pixels();
				end else begin
					m_hpos++;
				end
			end
			PH_PALETTE: begin
				if (m_bphase < 3) begin
					m_gather |= b << (8 * m_bphase);
					m_bphase++;
				end else begin
					emit(KIND_PALETTE, 0, 0, m_pal_slot, (m_gather >> 16) & 8'hFF,
						(m_gather >> 8) & 8'hFF, m_gather & 8'hFF, ERR_NOT_BMP);
					m_bphase = 0; m_gather = 0; m_pal_slot++;
					if (m_pal_slot >= m_pal_total) seek_pixels();
				end
			end
			PH_SKIP: if (m_fpos >= m_offset) begin_pixels();
			PH_PIXELS: begin
				if (m_pad > 0) begin
					m_pad--;
					if (m_pad == 0) close_row();
				end else begin
					m_mod = (m_mod + 1) & 3;
					if (m_depth == 24) begin
						m_gather |= b << (8 * m_bphase);
						if (m_bphase < 2) begin
							m_bphase++;
						end else begin
							emit(KIND_COLOR, m_col, m_row, 0, (m_gather >> 16) & 8'hFF,
								(m_gather >> 8) & 8'hFF, m_gather & 8'hFF, ERR_NOT_BMP);
							m_bphase = 0; m_gather = 0; m_col++;
						end
					end else begin
						per = 8 / m_depth;
						mask = (1 << m_depth) - 1;
						for (int i = 0; i < per; i++)
							if (m_col + i < m_width)
								emit(KIND_INDEX, m_col + i, m_row,
									(b >> (8 - m_depth * (i + 1))) & mask, 0, 0, 0, ERR_NOT_BMP);
						m_col += per;
					end
					// a 24-bit byte that ends no pixel cannot end the row
					if (!(m_depth == 24 && m_bphase != 0) && m_col >= m_width) begin
						if (((4 - m_mod) & 3) == 0) close_row();
						else m_pad = (4 - m_mod) & 3;
					end
				end
			end
			default: ;
		endcase
		if (expected_pix.size() > n0) expected_pix[expected_pix.size() - 1].last = 1;
	endtask

	// driver
	int src_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= 0;
			s_axis_tuser <= 0;
			src_wait = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_byte('{s_axis_tdata, s_axis_tuser});
				bytes_sent++;
				src_wait = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) src_wait = 0;
			end
			if (s_axis_tvalid && !s_axis_tready) begin
				// keep offering
			end else if (src_wait > 0) begin
				src_wait--;
				s_axis_tvalid <= 0;
			end else if (pending.size() > 0) begin
				byte_t it;
				it = pending.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tdata <= it.data;
				s_axis_tuser <= it.start;
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// monitor and sink pacing
	int sink_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			sink_wait = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				pix_t e;
				results_seen++;
				if (expected_pix.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h/%h/%b",
						$time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
				end else begin
					e = expected_pix.pop_front();
					if ({e.blue, e.green, e.red, e.index, e.row, e.col} !== m_axis_tdata ||
							{e.error_code, e.kind} !== m_axis_tuser ||
							e.last !== m_axis_tlast) begin
						errors++;
						$display("%0t: mismatch, expected %h/%h/%b, actual %h/%h/%b", $time,
							{e.error_code, e.kind},
							{e.blue, e.green, e.red, e.index, e.row, e.col}, e.last,
							m_axis_tuser, m_axis_tdata, m_axis_tlast);
					end
				end
				sink_wait = $urandom_range(0, 9);
				if ($urandom_range(0, 3) == 0) sink_wait = 0;
			end
			if (hold_sink) begin
				m_axis_tready <= 0;
			end else if (sink_wait > 0) begin
				sink_wait--;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	// long sink hold-off while the source keeps offering palette and pixel bytes
	initial begin
		wait (bytes_sent >= 40);
		hold_sink = 1;
		repeat (300) @(posedge clk);
		hold_sink = 0;
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= LIMIT_CYCLES) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	task automatic put_byte(int unsigned v, bit st = 0);
		byte_t it;
		it.data = v[7:0];
		it.start = st;
		pending.push_back(it);
	endtask

	task automatic put_word(int unsigned v, int nbytes);
		for (int i = 0; i < nbytes; i++) put_byte((v >> (8 * i)) & 8'hFF);
	endtask

	// one file; hdr_bad selects a header fault (0 none), a faulty file ends
	// right after the last checked header byte
	task automatic put_file(int unsigned w, int unsigned h, int unsigned dep,
			int unsigned off, int hdr_bad, int unsigned extra);
		int unsigned rowb, total;
		files_sent++;
		put_byte(hdr_bad == 1 ? $urandom_range(0, 255) : "B", 1);
		put_byte(hdr_bad == 1 ? "X" : "M");
		put_word($urandom, 4);
		put_word($urandom, 4);
		put_word(off, 4);
		put_word(hdr_bad == 2 ? 12 : 40, 4);
		put_word(w, 4);
		put_word(h, 4);
		put_word(hdr_bad == 3 ? 2 : 1, 2);
		put_word(hdr_bad == 5 ? 16 : dep, 2);
		put_word(hdr_bad == 4 ? 1 : 0, 4);
		if (hdr_bad != 0) return;
		for (int i = 0; i < 20; i++) put_byte($urandom_range(0, 255));
		rowb = ((w * dep + 31) / 32) * 4;
		total = (off > 54 ? off - 54 : 0) + rowb * h + extra;
		if (w > 16'hFFFF || h > 16'hFFFF) total = extra;
		for (int i = 0; i < total; i++) put_byte($urandom_range(0, 255));
	endtask

	function automatic int unsigned pick_depth();
		case ($urandom_range(0, 3))
			0: return 1;
			1: return 4;
			2: return 8;
			default: return 24;
		endcase
	endfunction

	initial begin
		int unsigned dep, pal;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;

		// directed: ignored bytes before any start, pixels past the width,
		// header faults and extremes
		put_byte(8'hFF); put_byte(8'h00);
		put_file(9, 2, 1, 54 + 8, 0, 3);
		put_file(3, 2, 1, 54 + 8, 1, 0);
		put_file(3, 2, 1, 54 + 8, 2, 0);
		put_file(3, 2, 1, 54 + 8, 3, 0);
		put_file(3, 2, 1, 54 + 8, 4, 0);
		put_file(3, 2, 1, 54 + 8, 5, 0);
		put_file(32'h10000, 1, 8, 54, 0, 3);
		put_file(0, 16'hFFFF, 8, 54, 0, 1);
		put_file(0, 2, 4, 54 + 8, 0, 0);

		// random files, most well formed
		while (bytes_sent + pending.size() < 440) begin
			dep = pick_depth();
			pal = (dep == 24) ? 0 : $urandom_range(0, 1 << (dep > 4 ? 4 : dep));
			if ($urandom_range(0, 7) == 0)
				put_file($urandom_range(1, 9), $urandom_range(1, 4), dep, 54 + 4 * pal,
					$urandom_range(1, 5), 0);
			else if ($urandom_range(0, 9) == 0)
				for (int i = 0; i < 12; i++) put_byte($urandom_range(0, 255), i == 0);
			else
				put_file($urandom_range(1, 13), $urandom_range(1, 4), dep,
					54 + 4 * pal + $urandom_range(0, 1) * $urandom_range(0, 6), 0,
					$urandom_range(0, 2));
		end

		wait (pending.size() == 0 && !s_axis_tvalid);
		wait (expected_pix.size() == 0);
		repeat (40) @(posedge clk);
		$display("covered %0d files, %0d bytes, %0d results checked",
			files_sent, bytes_sent, results_seen);
		if (errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		m_phase = PH_IDLE;
		m_hpos = 0; m_fpos = 0; m_shift = 0; m_offset = 0; m_width = 0; m_height = 0;
		m_depth = 0; m_pal_total = 0; m_pal_slot = 0; m_gather = 0; m_bphase = 0;
		m_col = 0; m_row = 0; m_mod = 0; m_pad = 0;
	end

endmodule

// ===== sim.f =====
rtl/bmp_pkg.sv
rtl/bmp_front.sv
rtl/bmp_back.sv
rtl/bmp_queue.sv
rtl/bmp_stream_decoder_unit.sv
bench/testbench.sv
